@@ rtl/rcfd_pkg.sv @@
// Package: constants and types shared by the RC channel frame decoder.
`timescale 1ns / 1ps

package rcfd_pkg;

    localparam logic [7:0]  HDR_BYTE   = 8'h20;
    localparam logic [15:0] SUM_INIT   = 16'hFFFF;
    localparam logic [5:0]  POS_HUNT   = 6'd0;
    localparam logic [5:0]  POS_WR_LO  = 6'd3;
    localparam logic [5:0]  POS_WR_HI  = 6'd29;
    localparam logic [5:0]  SUM_LEN    = 6'd30;
    localparam logic [5:0]  FRAME_LAST = 6'd31;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNEL_COUNT    = 2'd0,
        REG_SWITCH_THRESHOLD = 2'd1,
        REG_VALUE_OFFSET     = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic       bank;
        logic [3:0] count;
    } t_job;

    typedef struct packed {
        logic [1:0] bank_busy;
        logic       full;
        logic       empty;
    } t_q_stat;

endpackage

@@ rtl/rcfd_byte_if.sv @@
// Interface: serial byte input channel.
`timescale 1ns / 1ps

interface rcfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

@@ rtl/rcfd_result_if.sv @@
// Interface: channel result output channel.
`timescale 1ns / 1ps

interface rcfd_result_if;
    logic               valid;
    logic               ready;
    logic [3:0]         channel_index;
    logic [15:0]        channel_value;
    logic               switch_on;
    logic signed [16:0] offset_value;
    logic               last_channel;

    modport source (output valid, output channel_index, output channel_value,
                    output switch_on, output offset_value, output last_channel,
                    input ready);
    modport sink (input valid, input channel_index, input channel_value,
                  input switch_on, input offset_value, input last_channel,
                  output ready);
endinterface

@@ rtl/rcfd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rcfd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/rcfd_front.sv @@
// Front end: frame hunt, checksum, channel word store writes, job push.
`timescale 1ns / 1ps

module rcfd_front
    import rcfd_pkg::*;
#(
    parameter int MAX_CHANNELS = 14,
    parameter int CH_W         = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rcfd_byte_if.sink         rx,
    input  logic [3:0]        i_channel_count,
    input  t_q_stat           i_qstat,
    output logic              o_wr_en,
    output logic [CH_W:0]     o_wr_addr,
    output logic [15:0]       o_wr_data,
    output logic              o_push,
    output t_job              o_job
);

    logic [5:0]  r_pos,   n_pos;
    logic [15:0] r_sum,   n_sum;
    logic [7:0]  r_ck_lo, n_ck_lo;
    logic [7:0]  r_lo,    n_lo;
    logic        r_bank,  n_bank;

    logic        fire;
    logic        wr_pos;
    logic        stall;
    logic [5:0]  pos_m3;
    logic [4:0]  widx;
    logic        widx_ok;

    assign pos_m3  = r_pos - POS_WR_LO;
    assign widx    = pos_m3[5:1];
    assign widx_ok = ({27'd0, widx} < MAX_CHANNELS);
    assign wr_pos  = r_pos[0] && (r_pos inside {[POS_WR_LO:POS_WR_HI]});
    assign stall   = (wr_pos && i_qstat.bank_busy[r_bank]) ||
                     ((r_pos == FRAME_LAST) && i_qstat.full);
    assign rx.ready = !stall;
    assign fire     = rx.valid && !stall;

    assign o_wr_addr = {r_bank, widx[CH_W-1:0]};
    assign o_wr_data = {rx.rx_byte, r_lo};
    assign o_job     = '{bank: r_bank, count: i_channel_count};

    always_comb begin
        n_pos   = r_pos;
        n_sum   = r_sum;
        n_ck_lo = r_ck_lo;
        n_lo    = r_lo;
        n_bank  = r_bank;
        o_wr_en = 1'b0;
        o_push  = 1'b0;
        if (fire) begin
            if (r_pos == POS_HUNT) begin
                if (rx.rx_byte == HDR_BYTE) begin
                    n_sum = SUM_INIT - {8'd0, HDR_BYTE};
                    n_pos = 6'd1;
                end
            end else if (r_pos < SUM_LEN) begin
                n_sum = r_sum - {8'd0, rx.rx_byte};
                if (!r_pos[0]) begin
                    n_lo = rx.rx_byte;
                end
                o_wr_en = wr_pos && widx_ok;
                n_pos   = r_pos + 6'd1;
            end else if (r_pos == SUM_LEN) begin
                n_ck_lo = rx.rx_byte;
                n_pos   = r_pos + 6'd1;
            end else begin
                n_pos = POS_HUNT;
                n_sum = SUM_INIT;
                if ((r_pos == FRAME_LAST) && ({rx.rx_byte, r_ck_lo} == r_sum) &&
                    (i_channel_count != 4'd0)) begin
                    o_push = 1'b1;
                    n_bank = ~r_bank;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= POS_HUNT;
            r_sum   <= SUM_INIT;
            r_ck_lo <= 8'd0;
            r_bank  <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_sum   <= n_sum;
            r_ck_lo <= n_ck_lo;
            r_bank  <= n_bank;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo <= n_lo;
    end

`ifndef ASSERT_OFF
    a_wr_free_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> !i_qstat.bank_busy[r_bank])
        else $error("store write into a bank still being read");
`endif

endmodule

@@ rtl/rcfd_queue.sv @@
// Two-entry job queue between the front end and the result back end.
`timescale 1ns / 1ps

module rcfd_queue
    import rcfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_head,
    output t_q_stat o_stat
);

    logic [1:0] r_v, n_v;
    t_job       r_ent [2];
    logic       r_wp;
    logic       r_rp;

    assign o_head = r_ent[r_rp];
    assign o_stat.full  = r_v[r_wp];
    assign o_stat.empty = !r_v[r_rp];
    assign o_stat.bank_busy[0] = (r_v[0] && !r_ent[0].bank) || (r_v[1] && !r_ent[1].bank);
    assign o_stat.bank_busy[1] = (r_v[0] &&  r_ent[0].bank) || (r_v[1] &&  r_ent[1].bank);

    always_comb begin
        n_v = r_v;
        if (i_push) begin
            n_v[r_wp] = 1'b1;
        end
        if (i_pop) begin
            n_v[r_rp] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= 2'b00;
            r_wp <= 1'b0;
            r_rp <= 1'b0;
        end else begin
            r_v <= n_v;
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_job;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("job pushed into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("job popped from empty queue");
`endif

endmodule

@@ rtl/rcfd_back.sv @@
// Back end: reads stored channel words and issues one result item each.
`timescale 1ns / 1ps

module rcfd_back
    import rcfd_pkg::*;
#(
    parameter int CH_W = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_job          i_head,
    input  t_q_stat       i_qstat,
    input  logic [15:0]   i_rd_data,
    input  logic [15:0]   i_threshold,
    input  logic [15:0]   i_offset,
    output logic [CH_W:0] o_rd_addr,
    output logic          o_pop,
    rcfd_result_if.source res
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WAIT = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [3:0]         r_ch,    n_ch;
    logic [3:0]         r_idx;
    logic [15:0]        r_val;
    logic               r_sw;
    logic signed [16:0] r_off;
    logic               r_last;

    always_comb begin
        n_state = r_state;
        n_ch    = r_ch;
        o_pop   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_qstat.empty) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (res.ready) begin
                    if (r_last) begin
                        o_pop   = 1'b1;
                        n_ch    = 4'd0;
                        n_state = S_IDLE;
                    end else begin
                        n_ch    = r_ch + 4'd1;
                        n_state = S_WAIT;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
                n_ch    = 4'd0;
            end
        endcase
    end

    assign o_rd_addr = {i_head.bank, n_ch[CH_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ch    <= 4'd0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WAIT) begin
            r_idx  <= r_ch;
            r_val  <= i_rd_data;
            r_sw   <= (i_rd_data > i_threshold);
            r_off  <= signed'({1'b0, i_rd_data} - {1'b0, i_offset});
            r_last <= ((r_ch + 4'd1) == i_head.count);
        end
    end

    assign res.valid         = (r_state == S_OUT);
    assign res.channel_index = r_idx;
    assign res.channel_value = r_val;
    assign res.switch_on     = r_sw;
    assign res.offset_value  = r_off;
    assign res.last_channel  = r_last;

`ifndef ASSERT_OFF
    a_out_has_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.valid |-> !i_qstat.empty && (i_head.count != 4'd0))
        else $error("result item without a pending frame job");
`endif

endmodule

@@ rtl/rc_channel_frame_decoder_unit.sv @@
// Top level: RC channel frame decoder with config registers, store and queue.
//
//  channel   dir  payload                                       handshake
//  i_rx      in   rx_byte[7:0]                                  valid/ready
//  o_res     out  channel_index, channel_value, switch_on,      valid/ready
//                 offset_value[16:0] signed, last_channel
//  i_cfg_*   in   i_cfg_idx[1:0], i_cfg_data[15:0]              i_cfg_we
//
// One input byte is taken per cycle while the input does not stall; a frame holds 32 bytes.
// A valid frame leaves idle; each result passes a store read state, then an output state.
// Two store banks let the next frame be gathered while results drain; the byte input stalls
// only when a store write hits a bank still being read, or a frame end meets a full queue.
// Synchronous active-low reset; no clearing pass is needed.
`timescale 1ns / 1ps

module rc_channel_frame_decoder_unit
    import rcfd_pkg::*;
#(
    parameter int MAX_CHANNELS = 14
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    rcfd_byte_if.sink            i_rx,
    rcfd_result_if.source        o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]          i_cfg_data
);

    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int RAM_DEPTH = 2 << CH_W;
    localparam logic [3:0] MAX_CH4 = 4'(MAX_CHANNELS);

    logic [3:0]  r_channel_count;
    logic [15:0] r_switch_threshold;
    logic [15:0] r_value_offset;

    logic          wr_en;
    logic [CH_W:0] wr_addr;
    logic [15:0]   wr_data;
    logic [CH_W:0] rd_addr;
    logic [15:0]   rd_data;
    logic          push;
    logic          pop;
    t_job          job;
    t_job          head;
    t_q_stat       qstat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count    <= MAX_CH4;
            r_switch_threshold <= 16'd1500;
            r_value_offset     <= 16'd1500;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CHANNEL_COUNT: begin
                    r_channel_count <= (i_cfg_data[3:0] > MAX_CH4) ? MAX_CH4
                                                                   : i_cfg_data[3:0];
                end
                REG_SWITCH_THRESHOLD: begin
                    r_switch_threshold <= i_cfg_data;
                end
                REG_VALUE_OFFSET: begin
                    r_value_offset <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    rcfd_front #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .CH_W         (CH_W)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .rx              (i_rx),
        .i_channel_count (r_channel_count),
        .i_qstat         (qstat),
        .o_wr_en         (wr_en),
        .o_wr_addr       (wr_addr),
        .o_wr_data       (wr_data),
        .o_push          (push),
        .o_job           (job)
    );

    rcfd_ram #(
        .WIDTH (16),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    rcfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (qstat)
    );

    rcfd_back #(
        .CH_W (CH_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_qstat     (qstat),
        .i_rd_data   (rd_data),
        .i_threshold (r_switch_threshold),
        .i_offset    (r_value_offset),
        .o_rd_addr   (rd_addr),
        .o_pop       (pop),
        .res         (o_res)
    );

endmodule

@@ test/rcfd_channel_checker.sv @@
// Checker: predicts the channel results of the frame decoder and compares them with its output.
`timescale 1ns / 1ps

module rcfd_channel_checker
    import rcfd_pkg::*;
#(
    parameter int MAX_CHANNELS = 14
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    rcfd_byte_if                 i_rx,
    rcfd_result_if               i_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]          i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_frame_bytes,
    output int                   o_frames_ok,
    output int                   o_results_due,
    output int                   o_results_seen
);

    localparam int          STORE_DEPTH = 28;
    localparam logic [15:0] LEVEL_RESET = 16'd1500;

    typedef struct packed {
        logic [3:0]  index;
        logic [15:0] value;
        logic        switch_on;
        logic [16:0] offset;
        logic        last;
    } t_chan_result;

    logic [3:0]   chan_count;
    logic [15:0]  sw_thresh;
    logic [15:0]  val_offset;
    logic [5:0]   frame_pos;
    logic [15:0]  frame_sum;
    logic [7:0]   sum_lo;
    logic [7:0]   payload [STORE_DEPTH];
    t_chan_result channel_q [$];

    int fail_count   = 0;
    int pending      = 0;
    int frame_bytes  = 0;
    int frames_ok    = 0;
    int results_due  = 0;
    int results_seen = 0;

    assign o_fail_count   = fail_count;
    assign o_pending      = pending;
    assign o_frame_bytes  = frame_bytes;
    assign o_frames_ok    = frames_ok;
    assign o_results_due  = results_due;
    assign o_results_seen = results_seen;

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want, input logic [3:0] chan);
        if (got !== want) begin
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h (channel %0d)",
                                      name, got, want, chan));
        end
    endtask

    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        case (idx)
            REG_CHANNEL_COUNT: begin
                chan_count = (data[3:0] > MAX_CHANNELS) ? 4'(MAX_CHANNELS) : data[3:0];
            end
            REG_SWITCH_THRESHOLD: begin
                sw_thresh = data;
            end
            REG_VALUE_OFFSET: begin
                val_offset = data;
            end
            default: begin
            end
        endcase
    endtask

    task automatic take_byte(input logic [7:0] b);
        t_chan_result r;
        logic [15:0]  v;
        if (frame_pos != POS_HUNT || b == HDR_BYTE) frame_bytes++;
        if (frame_pos == POS_HUNT) begin
            if (b == HDR_BYTE) begin
                frame_sum = SUM_INIT - {8'd0, HDR_BYTE};
                frame_pos = 6'd1;
            end
        end else if (frame_pos < SUM_LEN) begin
            frame_sum = frame_sum - {8'd0, b};
            if (frame_pos >= 6'd2) payload[frame_pos - 6'd2] = b;
            frame_pos = frame_pos + 6'd1;
        end else if (frame_pos == SUM_LEN) begin
            sum_lo    = b;
            frame_pos = frame_pos + 6'd1;
        end else begin
            frame_pos = POS_HUNT;
            if ({b, sum_lo} == frame_sum) begin
                frames_ok++;
                for (int c = 0; c < chan_count; c++) begin
                    v           = {payload[2*c+1], payload[2*c]};
                    r.index     = 4'(c);
                    r.value     = v;
                    r.switch_on = (v > sw_thresh);
                    r.offset    = {1'b0, v} - {1'b0, val_offset};
                    r.last      = (c + 1 == chan_count);
                    channel_q.push_back(r);
                    results_due++;
                end
            end
            frame_sum = SUM_INIT;
        end
    endtask

    task automatic check_result();
        t_chan_result want;
        results_seen++;
        if (channel_q.size() == 0) begin
            report_mismatch($sformatf("channel %0d result arrived with nothing expected",
                                      i_res.channel_index));
        end else begin
            want = channel_q.pop_front();
            compare_field("channel_index", i_res.channel_index, want.index, want.index);
            compare_field("channel_value", i_res.channel_value, want.value, want.index);
            compare_field("switch_on", i_res.switch_on, want.switch_on, want.index);
            compare_field("offset_value", $unsigned(i_res.offset_value), want.offset,
                          want.index);
            compare_field("last_channel", i_res.last_channel, want.last, want.index);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            chan_count = 4'(MAX_CHANNELS);
            sw_thresh  = LEVEL_RESET;
            val_offset = LEVEL_RESET;
            frame_pos  = POS_HUNT;
            frame_sum  = SUM_INIT;
            sum_lo     = 8'd0;
            channel_q.delete();
        end else begin
            if (i_cfg_we) apply_write(i_cfg_idx, i_cfg_data);
            if (i_res.valid && i_res.ready) check_result();
            if (i_rx.valid && i_rx.ready) take_byte(i_rx.rx_byte);
        end
        pending = channel_q.size();
    end

endmodule

@@ test/tb_top.sv @@
// Testbench top: clock, reset, frame stimulus, register writes and the final verdict.
`timescale 1ns / 1ps

module tb_top;
    import rcfd_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 12;
    localparam int MAX_CH         = 14;
    localparam int FRAME_BYTES    = 32;
    localparam int SETTLE_CYCLES  = 80;
    localparam int HOLD_CYCLES    = 300;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int ITEM_TARGET    = 220;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam logic [7:0]           FRAME_CMD = 8'h40;

    localparam logic [15:0] EDGE_VALUES [MAX_CH] = '{
        16'h0000, 16'hFFFF, 16'd1499, 16'd1500, 16'd1501, 16'h2020, 16'h8000,
        16'h7FFF, 16'h0001, 16'hFFFE, 16'h00FF, 16'hFF00, 16'h5AA5, 16'hA55A
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [15:0]          cfg_data;

    rcfd_byte_if   rx_if ();
    rcfd_result_if res_if ();

    int fail_count;
    int pending;
    int frame_bytes;
    int frames_ok;
    int results_due;
    int results_seen;

    int          cycle_count = 0;
    int          burst_left  = 0;
    int          reg_writes  = 0;
    int          bytes_sent  = 0;
    bit          hold_req    = 1'b0;
    logic [15:0] cur_thr     = 16'd1500;
    logic [15:0] cur_off     = 16'd1500;
    logic [7:0]  frame_buf [FRAME_BYTES];

    rc_channel_frame_decoder_unit #(
        .MAX_CHANNELS(MAX_CH)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx      (rx_if),
        .o_res     (res_if),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    rcfd_channel_checker #(
        .MAX_CHANNELS(MAX_CH)
    ) u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx          (rx_if),
        .i_res         (res_if),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_frame_bytes (frame_bytes),
        .o_frames_ok   (frames_ok),
        .o_results_due (results_due),
        .o_results_seen(results_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Output side: random ready runs, plus one long hold-off on request.
    initial begin
        bit ready_level;
        int run_left;
        ready_level  = 1'b0;
        run_left     = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (run_left == 0) begin
                    ready_level = ~ready_level;
                    if (!ready_level) run_left = $urandom_range(1, 8);
                    else if ($urandom_range(0, 4) == 0) run_left = $urandom_range(50, 120);
                    else run_left = $urandom_range(1, 20);
                end
                run_left--;
                res_if.ready <= ready_level;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                rx_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < FRAME_BYTES; i++) send_byte(frame_buf[i]);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        if (idx == REG_SWITCH_THRESHOLD) cur_thr = data;
        if (idx == REG_VALUE_OFFSET) cur_off = data;
        reg_writes++;
    endtask

    // Block goes idle: input dropped, all results back, pipeline settled.
    task automatic drain();
        rx_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic put_channel(input int c, input logic [15:0] v);
        frame_buf[2 + 2*c] = v[7:0];
        frame_buf[3 + 2*c] = v[15:8];
    endtask

    task automatic seal_frame();
        logic [15:0] sum;
        sum = SUM_INIT;
        for (int i = 0; i < SUM_LEN; i++) sum = sum - {8'd0, frame_buf[i]};
        frame_buf[SUM_LEN]    = sum[7:0];
        frame_buf[FRAME_LAST] = sum[15:8];
    endtask

    task automatic load_edge_frame();
        frame_buf[0] = HDR_BYTE;
        frame_buf[1] = HDR_BYTE;
        for (int c = 0; c < MAX_CH; c++) put_channel(c, EDGE_VALUES[c]);
        seal_frame();
    endtask

    task automatic make_frame(input bit corrupt);
        logic [15:0] v;
        frame_buf[0] = HDR_BYTE;
        frame_buf[1] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : FRAME_CMD;
        for (int i = 2; i < SUM_LEN; i++) frame_buf[i] = 8'($urandom);
        for (int c = 0; c < MAX_CH; c++) begin
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 6))
                    0:       v = cur_thr - 16'd1;
                    1:       v = cur_thr;
                    2:       v = cur_thr + 16'd1;
                    3:       v = cur_off;
                    4:       v = cur_off - 16'd1;
                    5:       v = 16'h0000;
                    default: v = 16'hFFFF;
                endcase
                put_channel(c, v);
            end
        end
        seal_frame();
        if (corrupt) frame_buf[$urandom_range(0, FRAME_BYTES - 1)] ^= 8'($urandom_range(1, 255));
    endtask

    initial begin
        int         n_noise;
        logic [7:0] noise_byte;

        i_rst_n       = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = 8'd0;
        cfg_we        = 1'b0;
        cfg_idx       = REG_CHANNEL_COUNT;
        cfg_data      = 16'd0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: stray bytes, edge values, bad checksum
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h1F);
        send_byte(8'h21);
        load_edge_frame();
        send_frame();
        frame_buf[FRAME_LAST] ^= 8'h80;
        send_frame();
        drain();

        // zero channel count, write to the unused index
        write_reg(REG_CHANNEL_COUNT, 16'd0);
        write_reg(REG_SPARE, 16'hFFFF);
        make_frame(1'b0);
        send_frame();
        drain();

        // saturated count, lowest threshold, highest offset; output held off
        // while frames keep coming, so both banks fill and the input stalls
        write_reg(REG_CHANNEL_COUNT, 16'hFFFF);
        write_reg(REG_SWITCH_THRESHOLD, 16'h0000);
        write_reg(REG_VALUE_OFFSET, 16'hFFFF);
        hold_req = 1'b1;
        load_edge_frame();
        send_frame();
        repeat (2) begin
            make_frame(1'b0);
            send_frame();
        end
        drain();

        while (bytes_sent < ITEM_TARGET) begin
            write_reg(REG_CHANNEL_COUNT, 16'($urandom));
            if ($urandom_range(0, 1) == 0) write_reg(REG_SWITCH_THRESHOLD, 16'($urandom));
            if ($urandom_range(0, 1) == 0) write_reg(REG_VALUE_OFFSET, 16'($urandom));
            if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE, 16'($urandom));
            case ($urandom_range(0, 9))
                0: begin
                    n_noise = $urandom_range(1, 12);
                    repeat (n_noise) begin
                        noise_byte = 8'($urandom);
                        if (noise_byte == HDR_BYTE && $urandom_range(0, 3) != 0)
                            noise_byte = ~noise_byte;
                        send_byte(noise_byte);
                    end
                end
                1: begin
                    make_frame(1'b1);
                    send_frame();
                end
                default: begin
                    make_frame(1'b0);
                    send_frame();
                end
            endcase
            drain();
        end

        $display("Covered %0d input items (%0d in frames), %0d good frames, %0d of %0d results",
                 bytes_sent, frame_bytes, frames_ok, results_seen, results_due);
        $display("over %0d register writes: zero and saturated counts, extreme threshold/offset",
                 reg_writes);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ rc_channel_frame_decoder_unit.f @@
rtl/rcfd_pkg.sv
rtl/rcfd_byte_if.sv
rtl/rcfd_result_if.sv
rtl/rcfd_ram.sv
rtl/rcfd_front.sv
rtl/rcfd_queue.sv
rtl/rcfd_back.sv
rtl/rc_channel_frame_decoder_unit.sv
test/rcfd_channel_checker.sv
test/tb_top.sv
